// File: hw/rtl/pulse_height_analyzer_macros.svh
// assertion macros for the pulse height analyzer
`ifndef PULSE_HEIGHT_ANALYZER_MACROS_SVH
`define PULSE_HEIGHT_ANALYZER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define PHA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PHA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PHA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define PHA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/pha_pkg.sv
// shared types and constants of the pulse height analyzer
`timescale 1ns / 1ps
package pha_pkg;

  localparam int RECORD_LEN_DEFAULT   = 1024;
  localparam int BASELINE_LEN_DEFAULT = 200;
  localparam int NUM_BINS_DEFAULT     = 100;
  localparam int COUNT_WIDTH_DEFAULT  = 32;

  localparam int SAMPLE_W    = 16;
  localparam int AMPL_W      = 17;
  localparam int SEL_W       = 7;
  localparam int OUT_COUNT_W = 32;
  localparam int HIST_LOW_W  = 18;
  localparam int SCALE_W     = 24;
  localparam int SCALE_FRAC  = 16;
  localparam int DIFF_W      = 19;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

  localparam logic signed [HIST_LOW_W-1:0] HIST_LOW_RESET  = -18'sd10;
  localparam logic        [SCALE_W-1:0]    BIN_SCALE_RESET = 24'd131072;

  localparam logic [CFG_INDEX_W-1:0] REG_HIST_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_SCALE = 2'd1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic KIND_AMPL  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

  typedef struct packed {
    logic clearing;
  } status_t;

  typedef struct packed {
    logic                     kind;
    logic signed [AMPL_W-1:0] amplitude;
    logic [SEL_W-1:0]         bin_number;
    logic [OUT_COUNT_W-1:0]   bin_count;
  } result_t;

endpackage

// File: hw/rtl/pha_fifo.sv
// small register fifo used for the request queue and the result buffer
`timescale 1ns / 1ps
module pha_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push_valid,
  output logic                         push_ready,
  input  logic [DATA_W-1:0]            push_data,
  output logic                         pop_valid,
  input  logic                         pop_ready,
  output logic [DATA_W-1:0]            pop_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/pha_front.sv
// front end: accepts requests, tracks the record and queues work for the back end
`timescale 1ns / 1ps
module pha_front #(
  parameter int RECORD_LEN   = pha_pkg::RECORD_LEN_DEFAULT,
  parameter int BASELINE_LEN = pha_pkg::BASELINE_LEN_DEFAULT,
  parameter int SUM_W        = 24,
  parameter int Q_W          = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic signed [pha_pkg::SAMPLE_W-1:0] sample,
  input  logic [pha_pkg::SEL_W-1:0]           bin_select,
  input  pha_pkg::status_t                    status,
  output logic                                push_valid,
  input  logic                                push_ready,
  output logic [Q_W-1:0]                      push_data
);

  localparam int IDX_W = $clog2(RECORD_LEN);

  logic [IDX_W-1:0]                    sample_index;
  logic signed [pha_pkg::SAMPLE_W-1:0] running_minimum;
  logic signed [SUM_W-1:0]             baseline_sum;
  logic signed [pha_pkg::SAMPLE_W-1:0] minimum_next;
  logic signed [SUM_W-1:0]             baseline_sum_next;
  logic                                last;
  logic                                take_sample;

  assign in_ready    = !status.clearing && push_ready;
  assign take_sample = in_valid && in_ready && (op == pha_pkg::OP_SAMPLE);
  assign last        = (sample_index == IDX_W'(RECORD_LEN - 1));

  always_comb begin
    minimum_next = running_minimum;
    if ((sample_index == '0) || (sample < running_minimum)) begin
      minimum_next = sample;
    end
    baseline_sum_next = baseline_sum;
    if (32'(sample_index) < 32'(BASELINE_LEN)) begin
      baseline_sum_next = baseline_sum + SUM_W'(sample);
    end
  end

  // a read always goes to the back end, a sample only when it closes a record
  assign push_valid = in_valid && !status.clearing
                      && ((op == pha_pkg::OP_READ) || last);
  assign push_data  = {op, bin_select, baseline_sum_next, minimum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index    <= '0;
      running_minimum <= '0;
      baseline_sum    <= '0;
    end else if (take_sample) begin
      running_minimum <= minimum_next;
      if (last) begin
        sample_index <= '0;
        baseline_sum <= '0;
      end else begin
        sample_index <= sample_index + IDX_W'(1);
        baseline_sum <= baseline_sum_next;
      end
    end
  end

endmodule

// File: hw/rtl/pha_back.sv
// back end: amplitude, binning, histogram memory and result buffer
`timescale 1ns / 1ps
module pha_back #(
  parameter int BASELINE_LEN = pha_pkg::BASELINE_LEN_DEFAULT,
  parameter int NUM_BINS     = pha_pkg::NUM_BINS_DEFAULT,
  parameter int COUNT_WIDTH  = pha_pkg::COUNT_WIDTH_DEFAULT,
  parameter int SUM_W        = 24,
  parameter int Q_W          = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  pha_pkg::cfg_write_t cfg,
  output pha_pkg::status_t    status,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  logic [Q_W-1:0]      pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pha_pkg::result_t    result
);

  `include "pulse_height_analyzer_macros.svh"

  localparam int HIST_DEPTH = NUM_BINS + 2;
  localparam int BW         = $clog2(HIST_DEPTH);
  localparam int LB         = $clog2(BASELINE_LEN);
  localparam int K          = SUM_W + LB;
  localparam int MW         = SUM_W + 1;
  localparam int PROD_W     = SUM_W + MW;
  localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(BASELINE_LEN) - 64'd1)
                                  / 64'(BASELINE_LEN);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
  localparam int SP_W  = pha_pkg::DIFF_W - 1 + pha_pkg::SCALE_W;
  localparam int IDX_W = SP_W - pha_pkg::SCALE_FRAC;
  localparam int OCW   = $clog2(pha_pkg::OUT_DEPTH + 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_RUN   = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_AMP   = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_BIN   = 7'b0100000,
    ST_UPD   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [pha_pkg::HIST_LOW_W-1:0] hist_low;
  logic [pha_pkg::SCALE_W-1:0]           bin_scale;

  logic [BW-1:0] clr_addr;

  // queue item fields
  logic                                item_kind;
  logic [pha_pkg::SEL_W-1:0]           item_sel;
  logic signed [SUM_W-1:0]             item_sum;
  logic signed [pha_pkg::SAMPLE_W-1:0] item_min;

  // fill datapath registers
  logic signed [SUM_W-1:0]             sum_r;
  logic signed [pha_pkg::SAMPLE_W-1:0] min_r;
  logic                                neg_r;
  logic [PROD_W-1:0]                   prod_r;
  logic signed [pha_pkg::AMPL_W-1:0]   ampl_r;
  logic signed [pha_pkg::DIFF_W-1:0]   diff_r;
  logic [SP_W-1:0]                     scaled_r;

  logic [SUM_W-1:0]                    mag;
  logic [PROD_W-PROD_W+PROD_W-K-1:0]   quot;
  logic signed [pha_pkg::AMPL_W-1:0]   base;
  logic signed [pha_pkg::AMPL_W-1:0]   ampl;
  logic [IDX_W-1:0]                    idx;
  logic [BW-1:0]                       bin;

  // memory access stage
  logic                              p_valid;
  logic                              p_kind;
  logic [BW-1:0]                     p_addr;
  logic [pha_pkg::SEL_W-1:0]         p_bin;
  logic                              p_inrange;
  logic signed [pha_pkg::AMPL_W-1:0] p_ampl;

  logic [COUNT_WIDTH-1:0] hist [HIST_DEPTH];
  logic [COUNT_WIDTH-1:0] mem_q;
  logic [COUNT_WIDTH-1:0] count_new;
  logic                   mem_re;
  logic [BW-1:0]          raddr;
  logic                   mem_we;
  logic [BW-1:0]          waddr;
  logic [COUNT_WIDTH-1:0] wdata;

  logic               credit;
  logic               issue_read;
  logic               issue_fill;
  logic [OCW-1:0]     out_count;
  logic               res_push_ready;
  pha_pkg::result_t   res_push;
  logic [OCW:0]       used;

  assign status.clearing = (state == ST_CLEAR);

  assign item_kind = pop_data[Q_W-1];
  assign item_sel  = pop_data[Q_W-2 -: pha_pkg::SEL_W];
  assign item_sum  = pop_data[pha_pkg::SAMPLE_W +: SUM_W];
  assign item_min  = pop_data[pha_pkg::SAMPLE_W-1:0];

  // a memory access may start only if its result has a buffer slot
  assign used      = (OCW + 1)'(out_count) + (OCW + 1)'(p_valid);
  assign credit    = used < ((OCW + 1)'(pha_pkg::OUT_DEPTH)
                             + (OCW + 1)'(out_valid && out_ready));
  assign pop_ready = (state == ST_RUN) && credit;

  assign issue_read = pop_valid && pop_ready && (item_kind == pha_pkg::KIND_COUNT);
  assign issue_fill = (state == ST_BIN) && credit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_low  <= pha_pkg::HIST_LOW_RESET;
      bin_scale <= pha_pkg::BIN_SCALE_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == pha_pkg::REG_HIST_LOW) begin
        hist_low <= cfg.data[pha_pkg::HIST_LOW_W-1:0];
      end else if (cfg.index == pha_pkg::REG_BIN_SCALE) begin
        bin_scale <= cfg.data[pha_pkg::SCALE_W-1:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == BW'(HIST_DEPTH - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (pop_valid && pop_ready && (item_kind == pha_pkg::KIND_AMPL)) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:  state_next = ST_AMP;
      ST_AMP:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_BIN;
      ST_BIN: begin
        if (issue_fill) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD:  state_next = ST_RUN;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + BW'(1);
      end
    end
  end

  // baseline by reciprocal multiply on the magnitude, then amplitude and bin
  always_comb begin
    mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    quot = prod_r[PROD_W-1:K];
    base = neg_r ? -pha_pkg::AMPL_W'(quot) : pha_pkg::AMPL_W'(quot);
    ampl = base - pha_pkg::AMPL_W'(min_r);
    idx  = scaled_r[SP_W-1:pha_pkg::SCALE_FRAC];
    if (diff_r < 0) begin
      bin = '0;
    end else if (idx >= IDX_W'(NUM_BINS)) begin
      bin = BW'(NUM_BINS + 1);
    end else begin
      bin = BW'(idx) + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RUN) && pop_valid && pop_ready) begin
      sum_r <= item_sum;
      min_r <= item_min;
    end
    if (state == ST_DIV) begin
      neg_r  <= sum_r[SUM_W-1];
      prod_r <= PROD_W'(mag) * PROD_W'(RECIP_M);
    end
    if (state == ST_AMP) begin
      ampl_r <= ampl;
      diff_r <= pha_pkg::DIFF_W'(ampl) - pha_pkg::DIFF_W'(hist_low);
    end
    if (state == ST_MUL) begin
      scaled_r <= SP_W'(diff_r[pha_pkg::DIFF_W-2:0]) * SP_W'(bin_scale);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= issue_read || issue_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_read) begin
      p_kind    <= pha_pkg::KIND_COUNT;
      p_addr    <= BW'(item_sel);
      p_bin     <= item_sel;
      p_inrange <= 32'(item_sel) < 32'(HIST_DEPTH);
      p_ampl    <= '0;
    end else if (issue_fill) begin
      p_kind    <= pha_pkg::KIND_AMPL;
      p_addr    <= bin;
      p_bin     <= pha_pkg::SEL_W'(bin);
      p_inrange <= 1'b1;
      p_ampl    <= ampl_r;
    end
  end

  assign mem_re    = issue_read || issue_fill;
  assign raddr     = issue_read ? BW'(item_sel) : bin;
  assign count_new = (mem_q == '1) ? mem_q : mem_q + COUNT_WIDTH'(1);
  assign mem_we    = (state == ST_CLEAR) || (p_valid && (p_kind == pha_pkg::KIND_AMPL));
  assign waddr     = (state == ST_CLEAR) ? clr_addr : p_addr;
  assign wdata     = (state == ST_CLEAR) ? '0 : count_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[waddr] <= wdata;
    end
    if (mem_re) begin
      mem_q <= hist[raddr];
    end
  end

  always_comb begin
    res_push.kind       = p_kind;
    res_push.amplitude  = p_ampl;
    res_push.bin_number = p_bin;
    if (p_kind == pha_pkg::KIND_AMPL) begin
      res_push.bin_count = pha_pkg::OUT_COUNT_W'(count_new);
    end else if (p_inrange) begin
      res_push.bin_count = pha_pkg::OUT_COUNT_W'(mem_q);
    end else begin
      res_push.bin_count = '0;
    end
  end

  pha_fifo #(
    .DATA_W ($bits(pha_pkg::result_t)),
    .DEPTH  (pha_pkg::OUT_DEPTH)
  ) u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (p_valid),
    .push_ready (res_push_ready),
    .push_data  (res_push),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (result),
    .count      (out_count)
  );

  `PHA_ASSERT_IMPL(a_slot_for_access, clk, rst, p_valid, res_push_ready, "result buffer full at memory access")
  `PHA_ASSERT_IMPL(a_update_has_data, clk, rst, state == ST_UPD, p_valid && (p_kind == pha_pkg::KIND_AMPL), "histogram update without fill read")
  `PHA_ASSERT_NEXT(a_clear_runs_through, clk, rst, (state == ST_CLEAR) && (clr_addr != BW'(HIST_DEPTH - 1)), state == ST_CLEAR, "clear pass ended early")

endmodule

// File: hw/rtl/pulse_height_analyzer.sv
// top level of the pulse height analyzer
`timescale 1ns / 1ps
// Pulse height analyzer. Waveform samples (op 0) arrive one request per clock
// while in_ready is high; each record of RECORD_LEN samples yields one
// amplitude result, the baseline (sum of the first BASELINE_LEN samples divided
// by BASELINE_LEN, truncated toward zero) minus the record minimum, and that
// amplitude is counted in a histogram of NUM_BINS bins plus underflow (bin 0)
// and overflow (bin NUM_BINS+1). A read request (op 1) returns the saturating
// count of one bin. Sample and read requests are accepted at one per clock
// while no clear runs and the request queue has room. A record end is worked
// out by the back end in its states DIV, AMP, MUL, BIN and UPD (reciprocal
// multiply for the baseline, amplitude, bin scaling multiply, memory read,
// memory write), taking no new queue item before the last is through; a
// four-entry queue between front and back hides the gap for long records. After
// reset the histogram memory is cleared one bin per cycle, all NUM_BINS+2 bins,
// during which in_ready stays low; configuration writes are taken at any time.
module pulse_height_analyzer #(
  parameter int RECORD_LEN   = pha_pkg::RECORD_LEN_DEFAULT,
  parameter int BASELINE_LEN = pha_pkg::BASELINE_LEN_DEFAULT,
  parameter int NUM_BINS     = pha_pkg::NUM_BINS_DEFAULT,
  parameter int COUNT_WIDTH  = pha_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pha_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pha_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic signed [pha_pkg::SAMPLE_W-1:0]  sample,
  input  logic [pha_pkg::SEL_W-1:0]            bin_select,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 kind,
  output logic signed [pha_pkg::AMPL_W-1:0]    amplitude,
  output logic [pha_pkg::SEL_W-1:0]            bin_number,
  output logic [pha_pkg::OUT_COUNT_W-1:0]      bin_count
);

  // only as many samples as the record holds go into the baseline sum
  localparam int NSUM  = (BASELINE_LEN < RECORD_LEN) ? BASELINE_LEN : RECORD_LEN;
  localparam int SUM_W = pha_pkg::SAMPLE_W + $clog2(NSUM);
  // queue entry: kind, bin select, baseline sum, record minimum
  localparam int Q_W   = 1 + pha_pkg::SEL_W + SUM_W + pha_pkg::SAMPLE_W;

  pha_pkg::cfg_write_t cfg;
  pha_pkg::status_t    status;
  pha_pkg::result_t    result;

  logic           q_push_valid;
  logic           q_push_ready;
  logic [Q_W-1:0] q_push_data;
  logic           q_pop_valid;
  logic           q_pop_ready;
  logic [Q_W-1:0] q_pop_data;
  logic [$clog2(pha_pkg::QUEUE_DEPTH+1)-1:0] q_count;

  // registers are plain flops, a write never waits
  assign cfg_ready  = 1'b1;
  assign cfg.valid  = cfg_valid && cfg_ready;
  assign cfg.index  = cfg_index;
  assign cfg.data   = cfg_data;

  // front end: sample bookkeeping and request classification
  pha_front #(
    .RECORD_LEN   (RECORD_LEN),
    .BASELINE_LEN (BASELINE_LEN),
    .SUM_W        (SUM_W),
    .Q_W          (Q_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .sample     (sample),
    .bin_select (bin_select),
    .status     (status),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  // work queue between the two halves
  pha_fifo #(
    .DATA_W (Q_W),
    .DEPTH  (pha_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data),
    .count      (q_count)
  );

  // back end: amplitude, binning, histogram and result buffer
  pha_back #(
    .BASELINE_LEN (BASELINE_LEN),
    .NUM_BINS     (NUM_BINS),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .SUM_W        (SUM_W),
    .Q_W          (Q_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .status    (status),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign kind       = result.kind;
  assign amplitude  = result.amplitude;
  assign bin_number = result.bin_number;
  assign bin_count  = result.bin_count;

  `include "pulse_height_analyzer_macros.svh"

  `PHA_ASSERT_IMPL(a_queue_bound, clk, rst, q_push_valid && q_push_ready, q_count != 3'($unsigned(pha_pkg::QUEUE_DEPTH)), "request queue overrun")
  `PHA_ASSERT_IMPL(a_no_accept_in_clear, clk, rst, status.clearing, !in_ready, "request accepted during histogram clear")
  `PHA_ASSERT_NEXT(a_read_queued, clk, rst, in_valid && in_ready && (op == pha_pkg::OP_READ), q_pop_valid, "read request not queued")

endmodule
